### rtl/gbts_pkg.sv
// Package for the gap buffer text store: request and result payload types,
// operation and status codes, default capacity. No dependencies.
`default_nettype none

package gbts_pkg;

  localparam int GBTS_CAPACITY = 4096;

  localparam int GBTS_FUNC_W  = 3;
  localparam int GBTS_CHAR_W  = 8;
  localparam int GBTS_IDX_W   = 12;
  localparam int GBTS_STAT_W  = 2;
  localparam int GBTS_CNT_W   = 13;

  localparam logic [GBTS_FUNC_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [GBTS_FUNC_W-1:0] OP_LEFT      = 3'd1;
  localparam logic [GBTS_FUNC_W-1:0] OP_RIGHT     = 3'd2;
  localparam logic [GBTS_FUNC_W-1:0] OP_BACKSPACE = 3'd3;
  localparam logic [GBTS_FUNC_W-1:0] OP_DELETE    = 3'd4;
  localparam logic [GBTS_FUNC_W-1:0] OP_READ      = 3'd5;

  localparam logic [GBTS_STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [GBTS_STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [GBTS_STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [GBTS_FUNC_W-1:0] func;
    logic [GBTS_CHAR_W-1:0] char_in;
    logic [GBTS_IDX_W-1:0]  read_index;
  } gbts_req_t;

  typedef struct packed {
    logic [GBTS_STAT_W-1:0] status;
    logic [GBTS_CHAR_W-1:0] char_out;
    logic [GBTS_CNT_W-1:0]  cursor_pos;
    logic [GBTS_CNT_W-1:0]  text_length;
  } gbts_rsp_t;

endpackage

`default_nettype wire

### rtl/gbts_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/gap_buffer_text_store.sv
// Top level of the gap buffer text store: pointer control, sequencing and
// result register around one gbts_ram instance. Depends on gbts_pkg, gbts_ram.
`default_nettype none

// Fixed-capacity gap buffer of text bytes. Each request carries one
// operation (insert, left, right, backspace, delete, read) and yields exactly
// one result with a status, the read byte, the cursor position and the text
// length after the operation. The text lives in a single CAPACITY x 8 RAM
// with a registered read: text before the cursor at entries [0, cursor),
// text after it at [gap_end, CAPACITY). The accept cycle issues the RAM read
// (the byte to move for left and right, the addressed byte for read), and the
// completion state S_DONE does the write-back, updates the pointers and loads
// the result register. in_ready is high whenever no request is in progress,
// even while an earlier result still waits in the result register; a request
// only stalls in S_DONE if that register is still full. A new request is not
// accepted until the previous one has completed. The RAM needs no clearing
// after reset: every text byte is written before it can be read.
module gap_buffer_text_store
  #(
  parameter int CAPACITY = gbts_pkg::GBTS_CAPACITY
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gbts_pkg::gbts_req_t in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output gbts_pkg::gbts_rsp_t      out_data
);

  import gbts_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int PTR_W = $clog2(CAPACITY + 1);
  localparam int XW    = ((PTR_W > GBTS_IDX_W) ? PTR_W : GBTS_IDX_W) + 1;
  localparam logic [PTR_W-1:0] CAP_P = PTR_W'(CAPACITY);
  localparam logic [PTR_W-1:0] ONE_P = PTR_W'(1);

  // Sequencer codes
  localparam logic S_IDLE = 1'b0;
  localparam logic S_DONE = 1'b1;

  logic             state_r, state_nxt;
  logic [PTR_W-1:0] cursor_r, cursor_nxt;
  logic [PTR_W-1:0] gap_r, gap_nxt;
  gbts_req_t        req_r;
  logic             out_valid_r, out_valid_nxt;
  gbts_rsp_t        out_data_r, out_data_nxt;

  logic             in_fire;
  logic             slot_free;
  logic             done_fire;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;

  logic [XW-1:0]    idx_x, cur_x, gap_x, rd_pos_x;
  logic [PTR_W-1:0] cur_dec, gap_dec;
  logic [PTR_W-1:0] text_len;
  logic [PTR_W-1:0] text_len_nxt;
  logic [31:0]      cur_wide, len_wide;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  // Result register is free if empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign done_fire = (state_r == S_DONE) && slot_free;

  assign cur_dec  = cursor_r - ONE_P;
  assign gap_dec  = gap_r - ONE_P;
  assign text_len = cursor_r + (CAP_P - gap_r);

  // Read address for the accepted request: the byte to move, or the byte
  // at the requested logical position (before or after the gap).
  assign idx_x = XW'(in_data.read_index);
  assign cur_x = XW'(cursor_r);
  assign gap_x = XW'(gap_r);

  always_comb begin
    rd_en    = 1'b0;
    rd_pos_x = '0;
    unique case (in_data.func)
      OP_LEFT: begin
        rd_en    = in_fire;
        rd_pos_x = XW'(cur_dec);
      end
      OP_RIGHT: begin
        rd_en    = in_fire;
        rd_pos_x = gap_x;
      end
      OP_READ: begin
        rd_en    = in_fire;
        rd_pos_x = (idx_x < cur_x) ? idx_x : (gap_x + idx_x - cur_x);
      end
      default: begin
        rd_en    = 1'b0;
        rd_pos_x = '0;
      end
    endcase
  end

  assign rd_addr = rd_pos_x[AW-1:0];

  gbts_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_text_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Completion state S_DONE: write back, advance pointers, build the result
  always_comb begin
    cursor_nxt            = cursor_r;
    gap_nxt               = gap_r;
    wr_en                 = 1'b0;
    wr_addr               = cursor_r[AW-1:0];
    wr_data               = req_r.char_in;
    out_data_nxt          = out_data_r;
    out_data_nxt.status   = ST_OK;
    out_data_nxt.char_out = '0;
    unique case (req_r.func)
      OP_INSERT: begin
        if (cursor_r < gap_r) begin
          wr_en      = done_fire;
          cursor_nxt = cursor_r + ONE_P;
        end else begin
          out_data_nxt.status = ST_FULL;
        end
      end
      OP_LEFT: begin
        if (cursor_r != '0) begin
          wr_en      = done_fire;
          wr_addr    = gap_dec[AW-1:0];
          wr_data    = rd_data;
          cursor_nxt = cur_dec;
          gap_nxt    = gap_dec;
        end
      end
      OP_RIGHT: begin
        if (gap_r < CAP_P) begin
          wr_en      = done_fire;
          wr_data    = rd_data;
          cursor_nxt = cursor_r + ONE_P;
          gap_nxt    = gap_r + ONE_P;
        end
      end
      OP_BACKSPACE: begin
        if (cursor_r != '0) begin
          cursor_nxt = cur_dec;
        end
      end
      OP_DELETE: begin
        if (gap_r < CAP_P) begin
          gap_nxt = gap_r + ONE_P;
        end
      end
      OP_READ: begin
        if (XW'(req_r.read_index) < XW'(text_len)) begin
          out_data_nxt.char_out = rd_data;
        end else begin
          out_data_nxt.status = ST_RANGE;
        end
      end
      default: begin
        cursor_nxt = cursor_r;
      end
    endcase
    text_len_nxt             = cursor_nxt + (CAP_P - gap_nxt);
    cur_wide                 = 32'(cursor_nxt);
    len_wide                 = 32'(text_len_nxt);
    out_data_nxt.cursor_pos  = cur_wide[GBTS_CNT_W-1:0];
    out_data_nxt.text_length = len_wide[GBTS_CNT_W-1:0];
  end

  // Sequencer and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cursor_r    <= '0;
      gap_r       <= CAP_P;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // Hold pointers until the request completes
      if (done_fire) begin
        cursor_r <= cursor_nxt;
        gap_r    <= gap_nxt;
      end
    end
  end

  // Payload registers: latch the request on accept, the result on completion
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_data;
    end
    if (done_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r <= gap_r) && (gap_r <= CAP_P))
    else $error("gap pointers out of order");

  a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DONE))
    else $error("accepted request did not enter completion cycle");

  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !done_fire |=> ($stable(cursor_r) && $stable(gap_r)))
    else $error("pointers changed outside request completion");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> out_valid_r)
    else $error("completed request produced no result");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> done_fire)
    else $error("RAM write outside completion cycle");
`endif

endmodule

`default_nettype wire
